// ----- rtl/core/perceptron_branch_predictor_macros.svh -----
// Assertion macros shared by the perceptron branch predictor RTL.
`ifndef PERCEPTRON_BRANCH_PREDICTOR_MACROS_SVH
`define PERCEPTRON_BRANCH_PREDICTOR_MACROS_SVH

`ifndef SYNTHESIS
// Implication or plain property, checked on every rising edge outside reset.
`define PBP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Condition that must never hold outside reset.
`define PBP_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define PBP_ASSERT(lbl, clk, rst, prop, msg)
`define PBP_ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif

`endif

// ----- rtl/core/pbp_pkg.sv -----
// Types and constants of the perceptron branch predictor.
package pbp_pkg;

   localparam int HIST_LEN_DEF = 20;
   localparam int ROWS_DEF     = 512;

   localparam int PC_W      = 32;
   localparam int THETA_W   = 12;
   localparam int SUM_OUT_W = 13;
   localparam int WGT_W     = 8;

   localparam int W_MAX   = 127;
   localparam int W_MIN   = -126;
   localparam int REP_MAX = 4095;
   localparam int REP_MIN = -4096;

   localparam logic [THETA_W-1:0] THETA_RESET = 12'd54;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL,
      ST_SUB,
      ST_READ,
      ST_SUM,
      ST_UPD
   } state_type;

endpackage

// ----- rtl/core/pbp_channels.sv -----
// Request and response channel interfaces of the perceptron branch predictor.
interface pbp_req_if;
   logic                       valid;
   logic                       ready;
   logic [pbp_pkg::PC_W-1:0]   branch_pc;
   logic                       taken_outcome;

   modport source (output valid, output branch_pc, output taken_outcome, input ready);
   modport sink   (input valid, input branch_pc, input taken_outcome, output ready);
endinterface

interface pbp_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                predicted_taken;
   logic signed [pbp_pkg::SUM_OUT_W-1:0] perceptron_sum;
   logic                                did_train;

   modport source (output valid, output predicted_taken, output perceptron_sum,
                   output did_train, input ready);
   modport sink   (input valid, input predicted_taken, input perceptron_sum,
                   input did_train, output ready);
endinterface

// ----- rtl/core/perceptron_branch_predictor.sv -----
// Perceptron branch predictor: top level with row memory, index pipe and trainer.
//
// Each request item is one resolved conditional branch (PC and outcome); each
// gives exactly one response item: the prediction made from the row before
// training, the perceptron sum (saturated to 13 bits for reporting) and whether
// the row was trained. The row is ((pc * HIST_LEN) mod 2^32) mod ROWS, worked
// out by a reciprocal multiply plus one correction, so any ROWS works.
// Flow: an item passes through five steps in the block (reciprocal multiply,
// remainder, row read from the single-port-read weight memory, adder tree,
// write-back); the next item is taken in the write-back step, so an item is
// taken only once the one before it is through. A result waits in the output
// register while the next item is already being worked on; the write-back
// stalls only if that register is still full.
// After reset the weight memory is zeroed by a clearing pass over all ROWS
// rows (one row per cycle) during which no item is taken; threshold writes on the
// csr port are taken at any time and should only be made while idle.
module perceptron_branch_predictor #(
   parameter int HIST_LEN = pbp_pkg::HIST_LEN_DEF,
   parameter int ROWS     = pbp_pkg::ROWS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   pbp_req_if.sink                       req_bus,
   pbp_rsp_if.source                     rsp_bus,
   input  logic                          csr_wr_en,
   input  logic [pbp_pkg::THETA_W-1:0]   csr_wr_data
);

`include "perceptron_branch_predictor_macros.svh"

   localparam int ROW_LEN  = HIST_LEN + 1;
   localparam int ROW_BITS = pbp_pkg::WGT_W * ROW_LEN;
   localparam int ROW_W    = $clog2(ROWS);
   // worst case magnitude is ROW_LEN * 127, plus sign
   localparam int SUM_W    = $clog2(ROW_LEN * pbp_pkg::W_MAX + 1) + 1;
   localparam int CMP_W    = (SUM_W > pbp_pkg::SUM_OUT_W) ? SUM_W : pbp_pkg::SUM_OUT_W;
   localparam int LEAVES   = 1 << $clog2(ROW_LEN);

   localparam logic [31:0]     RECIP  = 32'((64'd1 << 32) / ROWS);
   localparam logic [ROW_W:0]  ROWS_V = (ROW_W + 1)'(ROWS);
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

   localparam logic signed [CMP_W-1:0] REP_HI = CMP_W'(pbp_pkg::REP_MAX);
   localparam logic signed [CMP_W-1:0] REP_LO = CMP_W'(pbp_pkg::REP_MIN);
   localparam logic signed [pbp_pkg::WGT_W-1:0] WT_HI = pbp_pkg::WGT_W'(pbp_pkg::W_MAX);
   localparam logic signed [pbp_pkg::WGT_W-1:0] WT_LO = pbp_pkg::WGT_W'(pbp_pkg::W_MIN);

   // control
   pbp_pkg::state_type state_ff, state_in;
   logic [ROW_W-1:0]   clr_ff;
   logic               req_rdy;
   logic               out_free;
   logic               upd_go;
   logic               train;

   // index pipe
   logic [31:0]        prod_ff;
   logic [31:0]        quot_ff;
   logic [ROW_W:0]     rem_ff;
   logic [ROW_W:0]     rem_fix;
   logic [ROW_W-1:0]   row_idx;
   logic [ROW_W-1:0]   row_ff;
   logic               taken_ff;
   logic [63:0]        recip_prod;
   logic [31:0]        diff;

   // weight memory
   logic [ROW_BITS-1:0] weight_mem [ROWS];
   logic [ROW_BITS-1:0] rd_row_ff;
   logic [ROW_BITS-1:0] new_row;
   logic                mem_we;
   logic                mem_re;
   logic [ROW_W-1:0]    mem_waddr;
   logic [ROW_BITS-1:0] mem_wdata;

   // arithmetic
   logic signed [SUM_W-1:0] tree [1:2*LEAVES-1];
   logic signed [SUM_W-1:0] sum_ff;
   logic signed [CMP_W-1:0] sum_x;
   logic signed [CMP_W-1:0] theta_x;
   logic signed [CMP_W-1:0] rep_x;
   logic                    pred;
   logic                    low_conf;

   logic [HIST_LEN-1:0]        hist_ff;
   logic [pbp_pkg::THETA_W-1:0] theta_ff;

   // response register
   logic                              rsp_valid_ff;
   logic                              rsp_pred_ff;
   logic signed [pbp_pkg::SUM_OUT_W-1:0] rsp_sum_ff;
   logic                              rsp_train_ff;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   // ---------------------------------------------------------------- FSM
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pbp_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      req_rdy  = 1'b0;
      upd_go   = 1'b0;
      mem_re   = 1'b0;
      case (state_ff)
         pbp_pkg::ST_CLEAR: begin
            if (clr_ff == LAST_ROW) state_in = pbp_pkg::ST_IDLE;
         end
         pbp_pkg::ST_IDLE: begin
            req_rdy = 1'b1;
            if (req_bus.valid) state_in = pbp_pkg::ST_MUL;
         end
         pbp_pkg::ST_MUL:  state_in = pbp_pkg::ST_SUB;
         pbp_pkg::ST_SUB:  state_in = pbp_pkg::ST_READ;
         pbp_pkg::ST_READ: begin
            mem_re   = 1'b1;
            state_in = pbp_pkg::ST_SUM;
         end
         pbp_pkg::ST_SUM:  state_in = pbp_pkg::ST_UPD;
         pbp_pkg::ST_UPD: begin
            if (out_free) begin
               upd_go   = 1'b1;
               req_rdy  = 1'b1;
               state_in = req_bus.valid ? pbp_pkg::ST_MUL : pbp_pkg::ST_IDLE;
            end
         end
         default: state_in = pbp_pkg::ST_CLEAR;
      endcase
   end

   assign req_bus.ready = req_rdy;

   // clearing pass row counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (state_ff == pbp_pkg::ST_CLEAR) begin
         clr_ff <= clr_ff + ROW_W'(1);
      end
   end

   // threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         theta_ff <= pbp_pkg::THETA_RESET;
      end else if (csr_wr_en) begin
         theta_ff <= csr_wr_data;
      end
   end

   // ---------------------------------------------------------- row index
   // q estimate is floor(p/ROWS) or one less, so the remainder is below 2*ROWS
   assign recip_prod = {32'd0, prod_ff} * {32'd0, RECIP};
   assign diff       = prod_ff - 32'(quot_ff * 32'(ROWS_V));
   assign rem_fix    = (rem_ff >= ROWS_V) ? (rem_ff - ROWS_V) : rem_ff;
   assign row_idx    = rem_fix[ROW_W-1:0];

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_rdy) begin
         prod_ff  <= 32'(req_bus.branch_pc * 32'(HIST_LEN));
         taken_ff <= req_bus.taken_outcome;
      end
      if (state_ff == pbp_pkg::ST_MUL) quot_ff <= recip_prod[63:32];
      if (state_ff == pbp_pkg::ST_SUB) rem_ff  <= diff[ROW_W:0];
      if (state_ff == pbp_pkg::ST_READ) row_ff <= row_idx;
   end

   // ------------------------------------------------------- weight memory
   assign mem_we    = (state_ff == pbp_pkg::ST_CLEAR) || (upd_go && train);
   assign mem_waddr = (state_ff == pbp_pkg::ST_CLEAR) ? clr_ff : row_ff;
   assign mem_wdata = (state_ff == pbp_pkg::ST_CLEAR) ? '0 : new_row;

   always_ff @(posedge clock) begin
      if (mem_we) weight_mem[mem_waddr] <= mem_wdata;
      if (mem_re) rd_row_ff <= weight_mem[row_idx];
   end

   // ------------------------------------------------------------ adder tree
   // leaf 0 is the bias (input fixed at 1); leaf k pairs with history bit k-1
   always_comb begin
      logic signed [pbp_pkg::WGT_W-1:0] w;
      logic                             xb;
      for (int n = 0; n < LEAVES; n++) begin
         if (n < ROW_LEN) begin
            w  = $signed(rd_row_ff[pbp_pkg::WGT_W*n +: pbp_pkg::WGT_W]);
            xb = (n == 0) ? 1'b1 : hist_ff[(n == 0) ? 0 : n - 1];
            tree[LEAVES + n] = xb ? SUM_W'(w) : -SUM_W'(w);
         end else begin
            tree[LEAVES + n] = '0;
         end
      end
      for (int n = LEAVES - 1; n >= 1; n--) begin
         tree[n] = tree[2*n] + tree[2*n + 1];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == pbp_pkg::ST_SUM) sum_ff <= tree[1];
   end

   // ------------------------------------------------------ decide & train
   assign sum_x    = CMP_W'(sum_ff);
   assign theta_x  = CMP_W'($signed({1'b0, theta_ff}));
   assign pred     = !sum_ff[SUM_W-1];
   assign low_conf = (sum_x < theta_x) && (sum_x > -theta_x);
   assign train    = (pred != taken_ff) || low_conf;
   assign rep_x    = (sum_x > REP_HI) ? REP_HI : ((sum_x < REP_LO) ? REP_LO : sum_x);

   always_comb begin
      logic signed [pbp_pkg::WGT_W-1:0] w;
      logic                             xb;
      new_row = rd_row_ff;
      for (int n = 0; n < ROW_LEN; n++) begin
         w  = $signed(rd_row_ff[pbp_pkg::WGT_W*n +: pbp_pkg::WGT_W]);
         xb = (n == 0) ? 1'b1 : hist_ff[(n == 0) ? 0 : n - 1];
         if (xb == taken_ff) begin
            if (w < WT_HI) w = w + pbp_pkg::WGT_W'(1);
         end else begin
            if (w > WT_LO) w = w - pbp_pkg::WGT_W'(1);
         end
         new_row[pbp_pkg::WGT_W*n +: pbp_pkg::WGT_W] = w;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff <= '0;
      end else if (upd_go) begin
         hist_ff <= (hist_ff << 1) | HIST_LEN'(taken_ff);
      end
   end

   // ------------------------------------------------------ response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (upd_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (upd_go) begin
         rsp_pred_ff  <= pred;
         rsp_sum_ff   <= rep_x[pbp_pkg::SUM_OUT_W-1:0];
         rsp_train_ff <= train;
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.predicted_taken = rsp_pred_ff;
   assign rsp_bus.perceptron_sum  = rsp_sum_ff;
   assign rsp_bus.did_train       = rsp_train_ff;

   // ------------------------------------------------------------ checks
   `PBP_ASSERT(a_clear_no_req, clock, reset, (state_ff == pbp_pkg::ST_CLEAR) |-> !req_bus.ready, "item taken during clearing pass")
   `PBP_ASSERT(a_write_phase, clock, reset, mem_we |-> (state_ff == pbp_pkg::ST_CLEAR || state_ff == pbp_pkg::ST_UPD), "weight write outside clear or write-back")
   `PBP_ASSERT(a_rsp_from_upd, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == pbp_pkg::ST_UPD), "response without write-back")
   `PBP_ASSERT_NEVER(a_row_range, clock, reset, (state_ff == pbp_pkg::ST_READ) && ({1'b0, row_idx} >= ROWS_V), "row index beyond ROWS")

endmodule

// ----- tb/perceptron_branch_predictor_test.sv -----
// Self-checking testbench of the perceptron branch predictor: random and directed branch streams.

typedef struct packed {
   logic                                 predicted_taken;
   logic signed [pbp_pkg::SUM_OUT_W-1:0] perceptron_sum;
   logic                                 did_train;
} branch_verdict_type;

// Mirror of the predictor state plus the queue of verdicts still owed by the block.
class perceptron_mirror;
   localparam int NHIST = pbp_pkg::HIST_LEN_DEF;
   localparam int NROWS = pbp_pkg::ROWS_DEF;

   logic signed [pbp_pkg::WGT_W-1:0] weights [NROWS][NHIST+1];
   logic [NHIST-1:0]                 history;
   logic [pbp_pkg::THETA_W-1:0]      theta;
   branch_verdict_type               owed_verdicts [$];
   int                               mismatches;

   function new();
      foreach (weights[r, c]) weights[r][c] = '0;
      history     = '0;
      theta       = pbp_pkg::THETA_RESET;
      mismatches  = 0;
   endfunction

   // Predict, train and shift history for one accepted branch.
   function void note_branch(input logic [31:0] pc, input logic taken);
      logic [31:0]        scaled;
      int                 row;
      int                 acc;
      int                 th;
      int                 clipped;
      logic               pred;
      logic               low_conf;
      logic               train;
      branch_verdict_type v;
      scaled   = pc * 32'(NHIST);
      row      = int'(scaled % 32'(NROWS));
      th       = int'(theta);
      acc      = int'(weights[row][0]);
      for (int i = 1; i <= NHIST; i++) begin
         if (history[i-1]) acc += int'(weights[row][i]);
         else acc -= int'(weights[row][i]);
      end
      pred     = (acc >= 0);
      low_conf = (acc < th) && (acc > -th);
      train    = (pred != taken) || low_conf;
      if (train) begin
         if (taken) begin
            if (weights[row][0] < pbp_pkg::W_MAX) weights[row][0] = weights[row][0] + 8'sd1;
         end else begin
            if (weights[row][0] > pbp_pkg::W_MIN) weights[row][0] = weights[row][0] - 8'sd1;
         end
         for (int i = 1; i <= NHIST; i++) begin
            if (history[i-1] == taken) begin
               if (weights[row][i] < pbp_pkg::W_MAX) weights[row][i] = weights[row][i] + 8'sd1;
            end else begin
               if (weights[row][i] > pbp_pkg::W_MIN) weights[row][i] = weights[row][i] - 8'sd1;
            end
         end
      end
      history = {history[NHIST-2:0], taken};
      clipped = acc;
      if (clipped > pbp_pkg::REP_MAX) clipped = pbp_pkg::REP_MAX;
      if (clipped < pbp_pkg::REP_MIN) clipped = pbp_pkg::REP_MIN;
      v.predicted_taken = pred;
      v.perceptron_sum  = clipped[pbp_pkg::SUM_OUT_W-1:0];
      v.did_train       = train;
      owed_verdicts.push_back(v);
   endfunction

   function void check_verdict(input logic pred, input logic signed [12:0] sum,
                               input logic train);
      branch_verdict_type v;
      if (owed_verdicts.size() == 0) begin
         $error("response item with no branch outstanding");
         mismatches++;
         return;
      end
      v = owed_verdicts.pop_front();
      if (pred !== v.predicted_taken) begin
         $error("predicted_taken: expected %0d, got %0d", v.predicted_taken, pred);
         mismatches++;
      end
      if (sum !== v.perceptron_sum) begin
         $error("perceptron_sum: expected %0d, got %0d",
                $signed(v.perceptron_sum), $signed(sum));
         mismatches++;
      end
      if (train !== v.did_train) begin
         $error("did_train: expected %0d, got %0d", v.did_train, train);
         mismatches++;
      end
   endfunction

   function bit settled();
      return owed_verdicts.size() == 0;
   endfunction
endclass

module perceptron_branch_predictor_test;

   // Cycles with no item moving on either channel before the run is declared hung.
   // Covers the clearing pass with plenty of margin.
   localparam int STALL_LIMIT = 4000;
   // Cycles allowed to pass after the last response before the verdict.
   localparam int TAIL_CYCLES = 20;

   typedef enum int {
      MOSTLY_TAKEN,
      MOSTLY_NOT_TAKEN,
      LOOP_EXIT
   } branch_habit_type;

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        csr_wr_en;
   logic [pbp_pkg::THETA_W-1:0] csr_wr_data;

   pbp_req_if req_bus ();
   pbp_rsp_if rsp_bus ();

   perceptron_mirror mirror = new();

   // When set, neither side inserts idle cycles.
   bit steady_spell = 1'b0;
   int idle_cycles  = 0;

   perceptron_branch_predictor i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Watchdog: counts edges at which no item moves on either channel.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles = idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // Response side: random back-pressure, each accepted item checked in order.
   initial begin
      int stall;
      rsp_bus.ready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         stall = steady_spell ? 0 : $urandom_range(0, 3);
         @(negedge clock);
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         mirror.check_verdict(rsp_bus.predicted_taken, rsp_bus.perceptron_sum,
                              rsp_bus.did_train);
      end
   end

   // One branch item: optional gap, then hold valid until the block takes it.
   // valid is only lowered when a gap is drawn, so back-to-back items keep it high.
   task automatic send_branch(input logic [31:0] pc, input logic taken);
      int gap;
      gap = steady_spell ? 0 : $urandom_range(0, 3);
      @(negedge clock);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.branch_pc     <= pc;
      req_bus.taken_outcome <= taken;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      mirror.note_branch(pc, taken);
   endtask

   // Sender goes quiet until every owed response item has come back.
   task automatic drain_requests();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (!mirror.settled()) @(posedge clock);
   endtask

   // Threshold writes only with the block idle.
   task automatic set_threshold(input logic [pbp_pkg::THETA_W-1:0] value);
      drain_requests();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      mirror.theta = value;
   endtask

   // Same branch over and over: with a huge threshold every item trains, so the
   // row runs into weight saturation and the sum reaches its extremes.
   task automatic hammer_row(input logic [31:0] pc, input logic taken, input int count);
      repeat (count) send_branch(pc, taken);
   endtask

   // Mostly a small working set of branches with learnable habits (some aliasing
   // onto one row), plus noise: random PCs and random outcomes.
   task automatic run_mix(input int count);
      logic [31:0]      pool_pc     [6];
      branch_habit_type pool_habit  [6];
      int               pool_period [6];
      int               pool_count  [6];
      int               pick;
      int               roll;
      logic             outcome;
      for (int k = 0; k < 6; k++) begin
         pool_pc[k]     = $urandom;
         pool_habit[k]  = branch_habit_type'($urandom_range(0, 2));
         pool_period[k] = $urandom_range(2, 6);
         pool_count[k]  = 0;
      end
      // 128 * HIST_LEN is a multiple of ROWS: these land on the row of entry 0
      pool_pc[4] = pool_pc[0] + 32'(128 * $urandom_range(1, 8));
      pool_pc[5] = pool_pc[0] + 32'(128 * $urandom_range(9, 64));
      for (int n = 0; n < count; n++) begin
         if (n % 40 == 0) steady_spell = ($urandom_range(0, 3) == 0);
         roll = $urandom_range(0, 99);
         pick = $urandom_range(0, 5);
         if (roll < 15) begin
            send_branch($urandom, 1'($urandom));
         end else if (roll < 25) begin
            send_branch(pool_pc[pick], 1'($urandom));
         end else begin
            case (pool_habit[pick])
               MOSTLY_TAKEN:     outcome = ($urandom_range(0, 9) != 0);
               MOSTLY_NOT_TAKEN: outcome = ($urandom_range(0, 9) == 0);
               default: begin
                  outcome = (pool_count[pick] % pool_period[pick]) != pool_period[pick] - 1;
                  pool_count[pick]++;
               end
            endcase
            send_branch(pool_pc[pick], outcome);
         end
         if ($urandom_range(0, 199) == 0) drain_requests();
      end
   endtask

   initial begin
      logic [31:0]                 dir_pc    [16];
      logic                        dir_taken [16];
      logic [pbp_pkg::THETA_W-1:0] th;

      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.branch_pc     = '0;
      req_bus.taken_outcome = 1'b0;
      csr_wr_en             = 1'b0;
      csr_wr_data           = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Directed: PC extremes, wrapping multiply, repeated rows flipping direction.
      dir_pc    = '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF, 32'h8000_0000, 32'h0CCC_CCCD, 32'h0000_0019,
                    32'h0000_001A, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0000,
                    32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001, 32'h0000_0000};
      dir_taken = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1,
                    1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
      set_threshold(pbp_pkg::THETA_RESET);
      for (int i = 0; i < 16; i++) send_branch(dir_pc[i], dir_taken[i]);

      // Zero threshold: nothing is low confidence, only wrong guesses train.
      set_threshold('0);
      send_branch(32'h0000_0040, 1'b1);
      send_branch(32'h0000_0040, 1'b1);
      send_branch(32'h0000_0040, 1'b0);
      send_branch(32'h0000_0040, 1'b0);
      send_branch(32'h0000_0040, 1'b1);

      // Largest threshold: drive two rows to full positive and negative saturation.
      set_threshold(12'hFFF);
      hammer_row(32'h0000_1234, 1'b1, 140);
      hammer_row(32'h0000_4321, 1'b0, 140);

      // Random phases, each behind a threshold change.
      for (int p = 0; p < 7; p++) begin
         case (p)
            0:       th = 12'hFFF;
            1:       th = '0;
            2:       th = 12'd1;
            3:       th = pbp_pkg::THETA_W'($urandom_range(0, 4095));
            4:       th = pbp_pkg::THETA_W'($urandom_range(2, 120));
            5:       th = pbp_pkg::THETA_RESET;
            default: th = pbp_pkg::THETA_W'($urandom_range(0, 4095));
         endcase
         set_threshold(th);
         run_mix(140);
      end

      steady_spell = 1'b0;
      drain_requests();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mirror.mismatches == 0 && mirror.settled()) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/pbp_pkg.sv
rtl/core/pbp_channels.sv
rtl/core/perceptron_branch_predictor.sv
tb/perceptron_branch_predictor_test.sv
